FILE: rtl/lpfd_pkg.sv
`default_nettype none
package lpfd_pkg;

   localparam int HEADER_BYTES_DEF = 4;
   localparam int LEN_W            = 32;
   localparam int CSR_IDX_W        = 1;

   localparam logic [LEN_W-1:0] WIRE_LIMIT_RST  = 32'd16777216;
   localparam logic [LEN_W-1:0] PARSE_LIMIT_RST = 32'd1048576;

   localparam logic [CSR_IDX_W-1:0] CSR_WIRE_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARSE_LIMIT = 1'd1;

   localparam logic [1:0] ST_BYTE      = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_TOO_LARGE = 2'd2;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       payload_byte;
      logic             last_byte;
      logic [LEN_W-1:0] declared_length;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/lpfd_parser.sv
`default_nettype none
module lpfd_parser #(
   parameter int HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_we,
   input  wire [lpfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [lpfd_pkg::LEN_W-1:0]     csr_wdata,
   input  wire                           in_accept,
   input  wire [7:0]                     in_byte,
   output logic                          out_push,
   output lpfd_pkg::rsp_type             out_item
);
   import lpfd_pkg::*;

   localparam int HDR_W = 8 * HEADER_BYTES;
   localparam int CNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam int CMP_W = HDR_W + LEN_W;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(HEADER_BYTES - 1);

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_DRAIN   = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [HDR_W-1:0] hdr_ff, hdr_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0] wire_limit_ff, parse_limit_ff;

   logic [HDR_W-1:0] declared;
   logic [LEN_W-1:0] left_dec;
   logic             over_wire, over_parse;

   assign declared   = hdr_ff | (HDR_W'(in_byte) << {cnt_ff, 3'b000});
   assign left_dec   = (left_ff == '0) ? '0 : left_ff - 1'b1;
   assign over_wire  = CMP_W'(declared) > CMP_W'(wire_limit_ff);
   assign over_parse = CMP_W'(declared) > CMP_W'(parse_limit_ff);

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      hdr_in   = hdr_ff;
      left_in  = left_ff;
      out_push = 1'b0;
      out_item = '{status: ST_BYTE, payload_byte: 8'd0, last_byte: 1'b0,
                   declared_length: '0};
      if (in_accept) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               out_push               = 1'b1;
               out_item.payload_byte  = in_byte;
               out_item.last_byte     = (left_ff <= 32'd1);
               left_in                = left_dec;
               if (left_dec == '0) phase_in = PH_HEADER;
            end
            PH_DRAIN: begin
               left_in = left_dec;
               if (left_dec == '0) phase_in = PH_HEADER;
            end
            default: begin
               phase_in = PH_HEADER;
               if (cnt_ff == LAST_CNT) begin
                  cnt_in = '0;
                  hdr_in = '0;
                  priority if (over_wire) begin
                     out_push                 = 1'b1;
                     out_item.status          = ST_TOO_LARGE;
                     out_item.declared_length = LEN_W'(declared);
                     left_in                  = '0;
                  end else if (over_parse) begin
                     left_in  = LEN_W'(declared);
                     phase_in = PH_DRAIN;
                  end else if (declared == '0) begin
                     out_push        = 1'b1;
                     out_item.status = ST_EMPTY;
                  end else begin
                     left_in  = LEN_W'(declared);
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  cnt_in = CNT_W'(cnt_ff + 1'b1);
                  hdr_in = declared;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         cnt_ff         <= '0;
         hdr_ff         <= '0;
         left_ff        <= '0;
         wire_limit_ff  <= WIRE_LIMIT_RST;
         parse_limit_ff <= PARSE_LIMIT_RST;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         hdr_ff   <= hdr_in;
         left_ff  <= left_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WIRE_LIMIT:  wire_limit_ff  <= csr_wdata;
               CSR_PARSE_LIMIT: parse_limit_ff <= csr_wdata;
               default:         ;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/lpfd_out_buf.sv
`default_nettype none
module lpfd_out_buf (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire lpfd_pkg::rsp_type push_item,
   output logic                   can_take,
   output logic                   out_valid,
   input  wire                    out_ready,
   output lpfd_pkg::rsp_type      out_item
);
   import lpfd_pkg::*;

   rsp_type    ent_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign can_take  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = ent_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/length_prefixed_frame_deframer_core.sv
// Length-prefixed frame deframer.
// req_ carries one stream byte per item (req_data_byte). Each frame is a
// HEADER_BYTES little-endian length followed by that many payload bytes.
// rsp_ gives at most one item per byte: a payload byte with rsp_last_byte
// on the final one, an empty-frame report, or a too-large error with the
// declared length. Length bytes other than the last, and drained bytes
// of a frame over parse_limit, give no item.
// csr_ writes wire_limit (index 0) and parse_limit (index 1); write them
// only while the block is idle.
// Throughput: one byte per cycle while req_ready is high. The item caused
// by a byte enters the result queue when req_ accepts it; the per-byte
// step is two length compares and one counter decrement, at accept time.
// A two-entry result queue parts the channels: req_ready stays high while
// one result waits, and drops only when both entries are held by a
// stalled receiver. Reset returns the parser to header collection, loads
// the default limits, empties the queue and holds req_ready low.
`default_nettype none
module length_prefixed_frame_deframer_core #(
   parameter int HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_we,
   input  wire [lpfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [lpfd_pkg::LEN_W-1:0]     csr_wdata,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire [7:0]                     req_data_byte,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_last_byte,
   output logic [lpfd_pkg::LEN_W-1:0]    rsp_declared_length
);
   import lpfd_pkg::*;

   logic    accept;
   logic    push;
   logic    buf_free;
   rsp_type push_item;
   rsp_type head_item;

   assign req_ready = buf_free && !reset;
   assign accept    = req_valid && req_ready;

   lpfd_parser #(.HEADER_BYTES(HEADER_BYTES)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_accept (accept),
      .in_byte   (req_data_byte),
      .out_push  (push),
      .out_item  (push_item)
   );

   lpfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .can_take  (buf_free),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head_item)
   );

   assign rsp_status          = head_item.status;
   assign rsp_payload_byte    = head_item.payload_byte;
   assign rsp_last_byte       = head_item.last_byte;
   assign rsp_declared_length = head_item.declared_length;

endmodule
`default_nettype wire

FILE: rtl/lpfd_checker.sv
`default_nettype none
module lpfd_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_status,
   input wire [7:0]  rsp_payload_byte,
   input wire        rsp_last_byte,
   input wire [31:0] rsp_declared_length
);
   import lpfd_pkg::*;

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result item dropped under stall");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_BYTE || rsp_status == ST_EMPTY ||
                     rsp_status == ST_TOO_LARGE))
      else $error("bad status code");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_BYTE |-> rsp_payload_byte == 8'd0 && !rsp_last_byte)
      else $error("report carries payload bits");

   a_byte_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BYTE || rsp_status == ST_EMPTY)
         |-> rsp_declared_length == 32'd0)
      else $error("length set on byte or empty item");

endmodule

bind length_prefixed_frame_deframer_core lpfd_checker u_lpfd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_payload_byte    (rsp_payload_byte),
   .rsp_last_byte       (rsp_last_byte),
   .rsp_declared_length (rsp_declared_length)
);
`default_nettype wire
